// ===== sv/eav_pkg.sv =====
// Shared types, codes and character classes for the email address validator.
// No dependencies; used by email_address_validator.
`timescale 1ns / 1ps
`default_nettype none

package eav_pkg;

    // Register file
    localparam int CFG_INDEX_WIDTH = 2;
    localparam int CFG_DATA_WIDTH  = 8;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_MAX_NAME_LENGTH   = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_MAX_DOMAIN_LENGTH = 2'd1;
    localparam logic [7:0] MAX_NAME_LENGTH_RESET   = 8'd64;
    localparam logic [7:0] MAX_DOMAIN_LENGTH_RESET = 8'd63;

    // Part lengths saturate at this value
    localparam logic [7:0] COUNT_MAX = 8'hFF;

    localparam logic [7:0] CHAR_AT  = 8'h40;
    localparam logic [7:0] CHAR_DOT = 8'h2E;

    // Result codes, first failure wins in this order
    typedef enum logic [2:0] {
        ERR_OK           = 3'd0,
        ERR_NAME_LENGTH  = 3'd1,
        ERR_NAME_CHARS   = 3'd2,
        ERR_NAME_DOTS    = 3'd3,
        ERR_DOMAIN_LENGTH = 3'd4,
        ERR_DOMAIN_CHARS = 3'd5,
        ERR_DOMAIN_DOTS  = 3'd6
    } err_t;

    // Letters, digits, dash and dot
    function automatic logic is_domain_char(input logic [7:0] c);
        logic ok;
        ok = ((c >= 8'h61) && (c <= 8'h7A))
          || ((c >= 8'h41) && (c <= 8'h5A))
          || ((c >= 8'h30) && (c <= 8'h39))
          || (c == 8'h2D) || (c == CHAR_DOT);
        return ok;
    endfunction

    // Domain set plus the printable specials allowed in a local name
    function automatic logic is_name_char(input logic [7:0] c);
        logic ok;
        ok = is_domain_char(c)
          || (c == 8'h21) || (c == 8'h23) || (c == 8'h24) || (c == 8'h25)
          || (c == 8'h26) || (c == 8'h27) || (c == 8'h2A) || (c == 8'h2B)
          || (c == 8'h2F) || (c == 8'h3D) || (c == 8'h3F) || (c == 8'h5E)
          || (c == 8'h5F) || (c == 8'h60) || (c == 8'h7B) || (c == 8'h7C)
          || (c == 8'h7D) || (c == 8'h7E);
        return ok;
    endfunction

endpackage

`default_nettype wire

// ===== sv/email_address_validator.sv =====
// Email address syntax checker, one byte per word, one code per address.
// Depends on eav_pkg for codes, register indexes and character classes.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+-------------------------
//   in      | sink      | in_valid / in_ready  | char_code, no_char, last
//   out     | source    | out_valid / out_ready| error_code
//   cfg     | sink      | cfg_write            | cfg_index, cfg_data
//
// One input word per cycle; the code of an address shows at out_valid in the
// cycle after its last word is taken. The per-part flags and counters update
// in the cycle a word is accepted; the code is set by one prioritized compare.
// in_ready drops only while a code sits in the output register and out_ready
// is low. Reset clears all flags and counts and loads the default lengths.
`timescale 1ns / 1ps
`default_nettype none

module email_address_validator (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic [7:0]                          char_code,
    input  wire logic                                no_char,
    input  wire logic                                last,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic [2:0]                               error_code,
    input  wire logic                                cfg_write,
    input  wire logic [eav_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  wire logic [eav_pkg::CFG_DATA_WIDTH-1:0]  cfg_data
);

    logic [7:0]    max_name_reg;
    logic [7:0]    max_domain_reg;

    logic          seen_at_reg;
    logic [7:0]    name_count_reg;
    logic [7:0]    domain_count_reg;
    logic          name_bad_reg;
    logic          domain_bad_reg;
    logic          name_dot_reg;
    logic          domain_dot_reg;
    logic          prev_dot_reg;

    logic          seen_at_next;
    logic [7:0]    name_count_next;
    logic [7:0]    domain_count_next;
    logic          name_bad_next;
    logic          domain_bad_next;
    logic          name_dot_next;
    logic          domain_dot_next;
    logic          prev_dot_next;

    logic          out_valid_reg;
    eav_pkg::err_t error_code_reg;
    eav_pkg::err_t error_code_next;

    logic          in_fire;
    logic          is_dot;
    logic          is_at;

    // Stall input only while a code waits and is not being taken
    assign in_ready   = !out_valid_reg || out_ready;
    assign in_fire    = in_valid && in_ready;
    assign out_valid  = out_valid_reg;
    assign error_code = error_code_reg;

    assign is_dot = (char_code == eav_pkg::CHAR_DOT);
    assign is_at  = (char_code == eav_pkg::CHAR_AT);

    // Fold one byte into the part it belongs to
    always_comb
    begin
        seen_at_next      = seen_at_reg;
        name_count_next   = name_count_reg;
        domain_count_next = domain_count_reg;
        name_bad_next     = name_bad_reg;
        domain_bad_next   = domain_bad_reg;
        name_dot_next     = name_dot_reg;
        domain_dot_next   = domain_dot_reg;
        prev_dot_next     = prev_dot_reg;
        if (!no_char)
        begin
            if (!seen_at_reg)
            begin
                if (is_at)
                begin
                    name_dot_next = name_dot_reg || prev_dot_reg;
                    seen_at_next  = 1'b1;
                    prev_dot_next = 1'b0;
                end
                else
                begin
                    name_bad_next = name_bad_reg || !eav_pkg::is_name_char(char_code);
                    name_dot_next = name_dot_reg || (is_dot &&
                                    ((name_count_reg == 8'd0) || prev_dot_reg));
                    if (name_count_reg != eav_pkg::COUNT_MAX)
                    begin
                        name_count_next = name_count_reg + 8'd1;
                    end
                    prev_dot_next = is_dot;
                end
            end
            else
            begin
                domain_bad_next = domain_bad_reg || !eav_pkg::is_domain_char(char_code);
                domain_dot_next = domain_dot_reg || (is_dot &&
                                  ((domain_count_reg == 8'd0) || prev_dot_reg));
                if (domain_count_reg != eav_pkg::COUNT_MAX)
                begin
                    domain_count_next = domain_count_reg + 8'd1;
                end
                prev_dot_next = is_dot;
            end
        end
    end

    // Pick the first failing check; a trailing dot faults the open part
    always_comb
    begin
        priority if ((name_count_next == 8'd0) || (name_count_next > max_name_reg))
        begin
            error_code_next = eav_pkg::ERR_NAME_LENGTH;
        end
        else if (name_bad_next)
        begin
            error_code_next = eav_pkg::ERR_NAME_CHARS;
        end
        else if (name_dot_next || (prev_dot_next && !seen_at_next))
        begin
            error_code_next = eav_pkg::ERR_NAME_DOTS;
        end
        else if ((domain_count_next == 8'd0) || (domain_count_next > max_domain_reg))
        begin
            error_code_next = eav_pkg::ERR_DOMAIN_LENGTH;
        end
        else if (domain_bad_next)
        begin
            error_code_next = eav_pkg::ERR_DOMAIN_CHARS;
        end
        else if (domain_dot_next || (prev_dot_next && seen_at_next))
        begin
            error_code_next = eav_pkg::ERR_DOMAIN_DOTS;
        end
        else
        begin
            error_code_next = eav_pkg::ERR_OK;
        end
    end

    // Hold length limits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_name_reg   <= eav_pkg::MAX_NAME_LENGTH_RESET;
            max_domain_reg <= eav_pkg::MAX_DOMAIN_LENGTH_RESET;
        end
        else if (cfg_write)
        begin
            if (cfg_index == eav_pkg::REG_MAX_NAME_LENGTH)
            begin
                max_name_reg <= cfg_data;
            end
            if (cfg_index == eav_pkg::REG_MAX_DOMAIN_LENGTH)
            begin
                max_domain_reg <= cfg_data;
            end
        end
    end

    // Advance part state; drop it after the last word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_at_reg      <= 1'b0;
            name_count_reg   <= 8'd0;
            domain_count_reg <= 8'd0;
            name_bad_reg     <= 1'b0;
            domain_bad_reg   <= 1'b0;
            name_dot_reg     <= 1'b0;
            domain_dot_reg   <= 1'b0;
            prev_dot_reg     <= 1'b0;
        end
        else if (in_fire)
        begin
            if (last)
            begin
                seen_at_reg      <= 1'b0;
                name_count_reg   <= 8'd0;
                domain_count_reg <= 8'd0;
                name_bad_reg     <= 1'b0;
                domain_bad_reg   <= 1'b0;
                name_dot_reg     <= 1'b0;
                domain_dot_reg   <= 1'b0;
                prev_dot_reg     <= 1'b0;
            end
            else
            begin
                seen_at_reg      <= seen_at_next;
                name_count_reg   <= name_count_next;
                domain_count_reg <= domain_count_next;
                name_bad_reg     <= name_bad_next;
                domain_bad_reg   <= domain_bad_next;
                name_dot_reg     <= name_dot_next;
                domain_dot_reg   <= domain_dot_next;
                prev_dot_reg     <= prev_dot_next;
            end
        end
    end

    // Output word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_fire && last)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && last)
        begin
            error_code_reg <= error_code_next;
        end
    end

    // A finished address leaves no state behind
    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && last |=> !seen_at_reg && (name_count_reg == 8'd0)
                            && (domain_count_reg == 8'd0) && !prev_dot_reg)
        else $error("part state not cleared after last word");

    // Words that are not last never raise a code
    a_no_code_midway: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && !last |=> !out_valid_reg || $past(out_valid_reg))
        else $error("code raised by a word that is not last");

    // An empty open part cannot end in a dot
    a_empty_part_no_dot: assert property (@(posedge clk) disable iff (!rst_n)
        (!seen_at_reg && (name_count_reg == 8'd0))
        || (seen_at_reg && (domain_count_reg == 8'd0)) |-> !prev_dot_reg)
        else $error("dot flag set on an empty part");

    // A held code is never overwritten before it is taken
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |-> !in_fire)
        else $error("input taken while output word is stalled");

endmodule

`default_nettype wire
